### hdl/tcgw_pkg.sv
// ----------------------------------------------------------------------------
// tcgw_pkg
// shared types and constants for the text console glyph writer
// ----------------------------------------------------------------------------
package tcgw_pkg;

    localparam int GLYPH_SIZE = 8;
    localparam int GLYPH_BITS = $clog2(GLYPH_SIZE);
    localparam int CELL_BITS  = 2 * GLYPH_BITS;

    localparam int COORD_W  = 13;
    localparam int OFFSET_W = 24;
    localparam int COLOR_W  = 32;
    localparam int CODE_W   = 8;
    localparam int CFG_W    = 32;
    localparam int CFG_AW   = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CODE_W-1:0] CODE_LF = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR = 8'd13;

    localparam logic [COORD_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [COORD_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [COORD_W-1:0] PITCH_RST  = 13'd640;
    localparam logic [COLOR_W-1:0] FG_RST     = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] BG_RST     = 32'h0000_0000;

    typedef enum logic [CFG_AW-1:0] {
        CFG_ENABLE = 3'd0,
        CFG_WIDTH  = 3'd1,
        CFG_HEIGHT = 3'd2,
        CFG_PITCH  = 3'd3,
        CFG_FG     = 3'd4,
        CFG_BG     = 3'd5
    } cfg_index_t;

    // one glyph cell waiting to be drawn
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CODE_W-1:0]  code;
    } cell_cmd_t;

endpackage

### hdl/text_console_glyph_writer.sv
// ----------------------------------------------------------------------------
// text_console_glyph_writer
// character stream to framebuffer pixel writes for an 8x8 text console
// ----------------------------------------------------------------------------
// While the console is enabled, each character transfer on the s_ side moves
// the cursor, and one other than line feed or carriage return also draws an
// 8x8 cell if it lies wholly on screen, which leaves the m_ side as 64 pixel
// writes in row-major order, one per cycle while m_tready does not stall, the
// 64th marked with m_tlast. Characters are taken one per cycle while the
// four-entry cell queue has room; control codes and cells that do not fit never
// enter it. A drawn cell holds the pixel generator for its 64 writes, which sets
// the sustained rate. Registers are written through cfg_we / cfg_addr /
// cfg_wdata and must only change while the block is idle.
// ----------------------------------------------------------------------------
module text_console_glyph_writer
    import tcgw_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [CFG_AW-1:0]            cfg_addr,
    input  logic [CFG_W-1:0]             cfg_wdata,
    // character input
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [CODE_W-1:0]            s_tdata,   // [7:0] char_code
    // pixel write output
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [OFFSET_W+COLOR_W-1:0]  m_tdata,   // [23:0] pixel_offset, [55:24] pixel_color
    output logic                         m_tlast    // last_pixel
);

    logic                console_enable_reg;
    logic [COORD_W-1:0]  screen_width_reg;
    logic [COORD_W-1:0]  screen_height_reg;
    logic [COORD_W-1:0]  pitch_words_reg;
    logic [COLOR_W-1:0]  ink_colour_reg;
    logic [COLOR_W-1:0]  paper_colour_reg;

    logic       q_push;
    cell_cmd_t  q_cmd;
    logic       q_full;
    logic       q_pop;
    logic       head_valid;
    cell_cmd_t  head_cmd;

    // register file, writes beyond the last index are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            console_enable_reg <= 1'b0;
            screen_width_reg   <= WIDTH_RST;
            screen_height_reg  <= HEIGHT_RST;
            pitch_words_reg    <= PITCH_RST;
            ink_colour_reg     <= FG_RST;
            paper_colour_reg   <= BG_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ENABLE: console_enable_reg <= cfg_wdata[0];
                CFG_WIDTH:  screen_width_reg   <= cfg_wdata[COORD_W-1:0];
                CFG_HEIGHT: screen_height_reg  <= cfg_wdata[COORD_W-1:0];
                CFG_PITCH:  pitch_words_reg    <= cfg_wdata[COORD_W-1:0];
                CFG_FG:     ink_colour_reg     <= cfg_wdata;
                CFG_BG:     paper_colour_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // front: decode and cursor
    tcgw_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .console_enable (console_enable_reg),
        .screen_width   (screen_width_reg),
        .screen_height  (screen_height_reg),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_cmd)
    );

    // cell queue decouples the two halves
    tcgw_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // back: pixel generation with registered output
    tcgw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pitch_words  (pitch_words_reg),
        .ink_colour   (ink_colour_reg),
        .paper_colour (paper_colour_reg),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

### hdl/tcgw_front.sv
// ----------------------------------------------------------------------------
// tcgw_front
// character decode and cursor tracking, queues cells that fit on screen
// ----------------------------------------------------------------------------
module tcgw_front
    import tcgw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                console_enable,
    input  logic [COORD_W-1:0]  screen_width,
    input  logic [COORD_W-1:0]  screen_height,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CODE_W-1:0]   s_tdata,
    input  logic                q_full,
    output logic                q_push,
    output cell_cmd_t           q_cmd
);

    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_W:0]   x_adv;
    logic [COORD_W:0]   y_adv;
    logic [COORD_W-1:0] y_wrapped;
    logic               accept;
    logic               fits;
    logic               is_glyph;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign x_adv     = {1'b0, cursor_x_reg} + (COORD_W+1)'(GLYPH_SIZE);
    assign y_adv     = {1'b0, cursor_y_reg} + (COORD_W+1)'(GLYPH_SIZE);
    assign y_wrapped = (y_adv >= {1'b0, screen_height}) ? '0 : y_adv[COORD_W-1:0];
    assign fits      = (x_adv <= {1'b0, screen_width}) && (y_adv <= {1'b0, screen_height});
    assign is_glyph  = (s_tdata != CODE_LF) && (s_tdata != CODE_CR);

    assign q_push     = accept && console_enable && is_glyph && fits;
    assign q_cmd.x    = cursor_x_reg;
    assign q_cmd.y    = cursor_y_reg;
    assign q_cmd.code = s_tdata;

    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (accept && console_enable) begin
            if (s_tdata == CODE_LF) begin
                cursor_x_next = '0;
                cursor_y_next = y_wrapped;
            end else if (s_tdata == CODE_CR) begin
                cursor_x_next = '0;
            end else if (x_adv >= {1'b0, screen_width}) begin
                cursor_x_next = '0;
                cursor_y_next = y_wrapped;
            end else begin
                cursor_x_next = x_adv[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end else begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

endmodule

### hdl/tcgw_fifo.sv
// ----------------------------------------------------------------------------
// tcgw_fifo
// short queue of cell commands between front and back
// ----------------------------------------------------------------------------
module tcgw_fifo
    import tcgw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cell_cmd_t  push_cmd,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output cell_cmd_t  head_cmd
);

    cell_cmd_t          entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/tcgw_back.sv
// ----------------------------------------------------------------------------
// tcgw_back
// pixel generator: walks cells by rows, one write per unstalled cycle
// ----------------------------------------------------------------------------
module tcgw_back
    import tcgw_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [COORD_W-1:0]           pitch_words,
    input  logic [COLOR_W-1:0]           ink_colour,
    input  logic [COLOR_W-1:0]           paper_colour,
    input  logic                         head_valid,
    input  cell_cmd_t                    head_cmd,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [OFFSET_W+COLOR_W-1:0]  m_tdata,
    output logic                         m_tlast
);

    logic [CELL_BITS-1:0]  cnt_reg;
    logic [GLYPH_BITS-1:0] row;
    logic [GLYPH_BITS-1:0] col;
    logic [COORD_W:0]      y_row;
    logic [COORD_W:0]      x_col;
    logic [2*COORD_W:0]    product;
    logic [CODE_W-1:0]     pattern;
    logic                  cell_end;
    logic                  adv;

    // stage one: row base product and glyph bit
    logic                  p1_valid_reg;
    logic [OFFSET_W-1:0]   p1_base_reg;
    logic [COORD_W:0]      p1_xcol_reg;
    logic                  p1_set_reg;
    logic                  p1_last_reg;

    // output register
    logic                  m_valid_reg;
    logic [OFFSET_W-1:0]   m_offset_reg;
    logic [COLOR_W-1:0]    m_color_reg;
    logic                  m_last_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign row      = cnt_reg[CELL_BITS-1:GLYPH_BITS];
    assign col      = cnt_reg[GLYPH_BITS-1:0];
    assign cell_end = (cnt_reg == '1);
    assign pop      = adv && head_valid && cell_end;

    assign y_row   = {1'b0, head_cmd.y} + (COORD_W+1)'(row);
    assign x_col   = {1'b0, head_cmd.x} + (COORD_W+1)'(col);
    assign product = y_row * pitch_words;
    assign pattern = head_cmd.code + CODE_W'(row);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= head_valid;
            m_valid_reg  <= p1_valid_reg;
            if (head_valid) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_base_reg  <= product[OFFSET_W-1:0];
            p1_xcol_reg  <= x_col;
            p1_set_reg   <= pattern[col];
            p1_last_reg  <= cell_end;
            m_offset_reg <= p1_base_reg + OFFSET_W'(p1_xcol_reg);
            m_color_reg  <= p1_set_reg ? ink_colour : paper_colour;
            m_last_reg   <= p1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_color_reg, m_offset_reg};
    assign m_tlast  = m_last_reg;

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the text console glyph writer
// ----------------------------------------------------------------------------
// Character codes are fed through the s_ stream and every pixel write that
// leaves the m_ stream is compared against a cycle-free predictor of the
// console: cursor, wrap rules, cell clipping and glyph colouring. The run
// starts with a disabled console and a short directed sequence on a tiny screen,
// then moves through several screen geometries and colour pairs with random
// text, including a disabled console, a zero-sized screen, maximum sizes and
// a cursor left beyond a freshly shrunk screen. Both stream sides are throttled
// at random in changing proportions, and neither is throttled in the last part.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcgw_pkg::*;

    // one framebuffer write as it should appear on the m_ side
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } pixel_write_t;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_AW-1:0]           cfg_addr  = '0;
    logic [CFG_W-1:0]            cfg_wdata = '0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [CODE_W-1:0]           s_tdata   = '0;   // [7:0] char_code
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [OFFSET_W+COLOR_W-1:0] m_tdata;          // [23:0] pixel_offset, [55:24] pixel_color
    logic                        m_tlast;          // last_pixel

    // characters still to be offered, pixel writes still owed by the block
    logic [CODE_W-1:0] pending_chars[$];
    pixel_write_t      expected_pixels[$];

    // console registers and cursor as the predictor sees them
    logic               con_enable = 1'b0;
    logic [COORD_W-1:0] scr_w      = WIDTH_RST;
    logic [COORD_W-1:0] scr_h      = HEIGHT_RST;
    logic [COORD_W-1:0] pitch      = PITCH_RST;
    logic [COLOR_W-1:0] fg         = FG_RST;
    logic [COLOR_W-1:0] bg         = BG_RST;
    logic [COORD_W-1:0] cur_x      = '0;
    logic [COORD_W-1:0] cur_y      = '0;

    int s_gap_pct   = 0;    // chance in a hundred that the sender holds back
    int m_stall_pct = 0;    // chance in a hundred that the receiver stalls
    int mismatches  = 0;
    bit char_taken  = 1'b0; // character transfer seen at the last rising edge

    text_console_glyph_writer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch on %s: got %h, expected %h at %0t ns",
                 field, got, want, $time);
    endtask

    // works out what one accepted character does to the console
    task automatic predict_glyph(input logic [CODE_W-1:0] code);
        int           nx;
        int           ny;
        bit           new_line;
        logic [7:0]   pattern;
        pixel_write_t px;
        if (!con_enable) begin
            return;
        end
        if (code == CODE_CR) begin
            cur_x = '0;
            return;
        end
        new_line = (code == CODE_LF);
        if (!new_line) begin
            // cell is drawn only when it lies wholly on screen
            if (cur_x + GLYPH_SIZE <= scr_w && cur_y + GLYPH_SIZE <= scr_h) begin
                for (int row = 0; row < GLYPH_SIZE; row++) begin
                    pattern = 8'(code + row);
                    for (int col = 0; col < GLYPH_SIZE; col++) begin
                        px.offset = OFFSET_W'((cur_y + row) * pitch + cur_x + col);
                        px.color  = pattern[col] ? fg : bg;
                        px.last   = (row == GLYPH_SIZE - 1) && (col == GLYPH_SIZE - 1);
                        expected_pixels.push_back(px);
                    end
                end
            end
            // the cursor moves on whether or not the cell was drawn
            nx = cur_x + GLYPH_SIZE;
            if (nx >= scr_w) begin
                new_line = 1'b1;
            end else begin
                cur_x = COORD_W'(nx);
            end
        end
        if (new_line) begin
            ny    = cur_y + GLYPH_SIZE;
            cur_x = '0;
            cur_y = (ny >= scr_h) ? '0 : COORD_W'(ny);
        end
    endtask

    // sampling at the rising edge: inputs and outputs are settled by then
    always @(posedge aclk) begin
        pixel_write_t want;
        char_taken = aresetn && s_tvalid && s_tready;
        if (char_taken) begin
            predict_glyph(s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected pixel write", m_tdata, '0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[OFFSET_W-1:0] !== want.offset) begin
                    report_mismatch("pixel_offset", m_tdata[OFFSET_W-1:0], want.offset);
                end
                if (m_tdata[OFFSET_W +: COLOR_W] !== want.color) begin
                    report_mismatch("pixel_color", m_tdata[OFFSET_W +: COLOR_W], want.color);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last_pixel", m_tlast, want.last);
                end
            end
        end
    end

    // driving at the falling edge: random sender gaps and receiver stalls
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= m_stall_pct);
        if (aresetn && (!s_tvalid || char_taken)) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= s_gap_pct) begin
                s_tdata  <= pending_chars.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        // block is idle, so the predictor may take the new value at once
        case (idx)
            CFG_ENABLE: con_enable = data[0];
            CFG_WIDTH:  scr_w      = data[COORD_W-1:0];
            CFG_HEIGHT: scr_h      = data[COORD_W-1:0];
            CFG_PITCH:  pitch      = data[COORD_W-1:0];
            CFG_FG:     fg         = data;
            CFG_BG:     bg         = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // junk above each narrow register checks that only its low bits stick
    task automatic configure(input bit en, input int w, input int h, input int p,
                             input logic [COLOR_W-1:0] fg_val,
                             input logic [COLOR_W-1:0] bg_val);
        write_reg(CFG_ENABLE, ($urandom() << 1) | en);
        write_reg(CFG_WIDTH, ($urandom() << COORD_W) | w);
        write_reg(CFG_HEIGHT, ($urandom() << COORD_W) | h);
        write_reg(CFG_PITCH, ($urandom() << COORD_W) | p);
        write_reg(CFG_FG, fg_val);
        write_reg(CFG_BG, bg_val);
    endtask

    // waits until every character is taken and every pixel write is back,
    // then lets the block settle before the next step
    task automatic wait_idle();
        do begin
            @(posedge aclk);
        end while (pending_chars.size() != 0 || s_tvalid || expected_pixels.size() != 0);
        repeat (16) @(posedge aclk);
    endtask

    // random byte codes with line feeds and carriage returns mixed in
    task automatic run_text(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                pending_chars.push_back(CODE_LF);
            end else if (pick < 18) begin
                pending_chars.push_back(CODE_CR);
            end else begin
                pending_chars.push_back(CODE_W'($urandom_range(255)));
            end
        end
        wait_idle();
    endtask

    initial begin
        logic [CODE_W-1:0] directed_chars[] = '{
            8'h00, 8'hFF, 8'h41, CODE_CR, 8'h7F, CODE_CR, 8'h80, CODE_LF,
            8'hFB, 8'hF8, CODE_LF, CODE_LF, 8'h55, 8'hAA
        };

        // sender lightly idle, receiver heavily stalled
        s_gap_pct   = 21;
        m_stall_pct = 68;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // console disabled out of reset: nothing drawn, cursor stays home
        pending_chars.push_back(8'h41);
        pending_chars.push_back(CODE_LF);
        pending_chars.push_back(8'hFF);
        wait_idle();

        // tiny screen: fits, clipped cell, wraps on width and height, code+row wrap
        configure(1'b1, 20, 16, 20, 32'hFFFF_FFFF, 32'h0000_0000);
        foreach (directed_chars[i]) begin
            pending_chars.push_back(directed_chars[i]);
        end
        wait_idle();

        configure(1'b1, 64, 32, 80, $urandom(), $urandom());
        run_text(40);

        // disabled again mid-run: cursor must survive untouched
        configure(1'b0, 64, 32, 80, $urandom(), $urandom());
        run_text(8);

        // the other way round: sender mostly idle, receiver mostly ready
        s_gap_pct   = 68;
        m_stall_pct = 21;

        // largest sizes; walk the cursor far down the screen
        configure(1'b1, 8191, 8191, 8191, $urandom(), $urandom());
        repeat (40) pending_chars.push_back(CODE_LF);
        run_text(15);

        // screen shrinks under a cursor that now lies beyond it
        configure(1'b1, 64, 32, 64, $urandom(), $urandom());
        run_text(30);

        // no throttling on either side
        s_gap_pct   = 0;
        m_stall_pct = 0;

        // zero-sized screen: nothing fits and every wrap fires
        configure(1'b1, 0, 0, 4095, $urandom(), $urandom());
        run_text(10);

        configure(1'b1, 4096, 4096, 4096, $urandom(), $urandom());
        run_text(15);

        // one cell exactly, zero pitch, colours swapped to the other extremes
        configure(1'b1, 8, 8, 0, 32'h0000_0000, 32'hFFFF_FFFF);
        run_text(10);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(10_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

### text_console_glyph_writer.f
hdl/tcgw_pkg.sv
hdl/tcgw_front.sv
hdl/tcgw_fifo.sv
hdl/tcgw_back.sv
hdl/text_console_glyph_writer.sv
dv/testbench.sv
